### src/sirt_pkg.sv
// Shared types and codes for the sorted record table.
package sirt_pkg;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 8;
   localparam int REC_W   = KEY_W + VALUE_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RECORD   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_LAST,
      ST_DUMP,
      ST_RESP
   } state_type;

endpackage

### src/sirt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sirt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sorted_insert_record_table_core.sv
// Sorted record table: up to DEPTH (key, value) records held in ascending key order.
//
// Request channel (req_valid / req_stall): opcode insert places the record before the
// first stored record whose key is not smaller; opcode dump reads every record out.
// One request is worked on at a time; req_stall is high while one is in progress.
// Response channel (rsp_valid / rsp_stall): an insert answers one response (inserted,
// or full and dropped); a dump answers one response per record, the last one flagged,
// or a single empty response. Non-record responses carry zero key and value.
// Records live in one RAM with a registered read. An insert walks down from the top
// entry, one stored record read and moved up per cycle, until it reaches a record with
// a key smaller than the new one or the bottom entry, and then writes the new record.
// A dump streams one record per cycle while the response side does not stall, behind
// the registered RAM read. A full insert or empty dump answers without a RAM access.
// The block returns to idle in the same cycle that the final response of a request is
// registered.
// A stalled response holds in the output register; the block may already take the
// next request, and stalls the request side only when a further response is due.
// Synchronous reset empties the table and drops any pending response; RAM contents
// are not cleared, as entries above the fill count are never read.
module sorted_insert_record_table_core #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [sirt_pkg::KEY_W-1:0] req_rec_key,
   input  logic [sirt_pkg::VALUE_W-1:0] req_rec_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [sirt_pkg::KEY_W-1:0] rsp_out_key,
   output logic [sirt_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                       rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sirt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [1:0]                   status_ff, status_in;
   logic [sirt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [sirt_pkg::VALUE_W-1:0] value_ff, value_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [sirt_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [sirt_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_take;
   logic                         out_free;
   logic                         out_load;
   logic                         is_full;
   logic                         is_empty;
   logic                         dump_last;
   logic                         shift_up;
   logic [sirt_pkg::KEY_W-1:0]   rd_key;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [sirt_pkg::REC_W-1:0]   wr_data;
   logic [AW-1:0]                rd_addr;
   logic [sirt_pkg::REC_W-1:0]   rd_data;

   sirt_ram #(
      .WIDTH (sirt_pkg::REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != sirt_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign dump_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign rd_key    = rd_data[sirt_pkg::REC_W-1 -: sirt_pkg::KEY_W];
   // equal keys move up too, so the new record lands below them
   assign shift_up  = (rd_key >= key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sirt_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == sirt_pkg::OP_DUMP) begin
                  state_in = is_empty ? sirt_pkg::ST_RESP : sirt_pkg::ST_DUMP;
               end else if (is_full) begin
                  state_in = sirt_pkg::ST_RESP;
               end else if (is_empty) begin
                  state_in = sirt_pkg::ST_INS_LAST;
               end else begin
                  state_in = sirt_pkg::ST_INS_SCAN;
               end
            end
         end
         sirt_pkg::ST_INS_SCAN: begin
            if (shift_up) begin
               state_in = (pos_ff == AW'(1)) ? sirt_pkg::ST_INS_LAST : sirt_pkg::ST_INS_SCAN;
            end else begin
               state_in = sirt_pkg::ST_RESP;
            end
         end
         sirt_pkg::ST_INS_LAST: begin
            state_in = sirt_pkg::ST_RESP;
         end
         sirt_pkg::ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = sirt_pkg::ST_IDLE;
            end
         end
         sirt_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = sirt_pkg::ST_IDLE;
            end
         end
         default: state_in = sirt_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {key_ff, value_ff};
      out_load      = 1'b0;
      rsp_status_in = status_ff;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         sirt_pkg::ST_IDLE: begin
            // the first read goes out with the request: top entry for insert, entry 0 for dump
            rd_addr = (req_opcode == sirt_pkg::OP_DUMP) ? '0 : AW'(count_ff - CW'(1));
            if (req_take) begin
               key_in   = req_rec_key;
               value_in = req_rec_value;
               pos_in   = AW'(count_ff);
               idx_in   = '0;
               if (req_opcode == sirt_pkg::OP_DUMP) begin
                  status_in = sirt_pkg::STATUS_EMPTY;
               end else if (is_full) begin
                  status_in = sirt_pkg::STATUS_FULL;
               end else begin
                  status_in = sirt_pkg::STATUS_INSERTED;
               end
            end
         end
         sirt_pkg::ST_INS_SCAN: begin
            // rd_data holds entry pos-1; next read is pos-2, clear of the write at pos
            rd_addr = pos_ff - AW'(2);
            wr_en   = 1'b1;
            if (shift_up) begin
               wr_data = rd_data;
               pos_in  = pos_ff - AW'(1);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         sirt_pkg::ST_INS_LAST: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         sirt_pkg::ST_DUMP: begin
            // hold the read address while the output register is blocked
            rd_addr       = out_free ? (idx_ff + AW'(1)) : idx_ff;
            out_load      = out_free;
            rsp_status_in = sirt_pkg::STATUS_RECORD;
            rsp_key_in    = rd_key;
            rsp_value_in  = rd_data[sirt_pkg::VALUE_W-1:0];
            rsp_last_in   = dump_last;
            if (out_free) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         sirt_pkg::ST_RESP: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sirt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### src/sirt_monitor.sv
// Port-level assertions for the sorted record table, bound to the top level.
module sirt_monitor (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [sirt_pkg::KEY_W-1:0]   rsp_out_key,
   input logic [sirt_pkg::VALUE_W-1:0] rsp_out_value,
   input logic                         rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_key)
         && $stable(rsp_out_value) && $stable(rsp_last))
      else $error("stalled response changed");

   // status responses are always the final one of their request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sirt_pkg::STATUS_RECORD |-> rsp_last)
      else $error("status response without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sirt_pkg::STATUS_RECORD |->
         rsp_out_key == '0 && rsp_out_value == '0)
      else $error("status response carries record data");

   // every request keeps the block busy for at least the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after a request");

endmodule

bind sorted_insert_record_table_core sirt_monitor u_sirt_monitor (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_key   (rsp_out_key),
   .rsp_out_value (rsp_out_value),
   .rsp_last      (rsp_last)
);

### tb/sorted_insert_record_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted record table, driven by directed and random requests.
module sorted_insert_record_table_core_tb;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 220;
   localparam int MAX_WAIT      = 16;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [1:0]                   status;
      logic [sirt_pkg::KEY_W-1:0]   key;
      logic [sirt_pkg::VALUE_W-1:0] value;
      logic                         last;
   } answer_type;

   // Keeps its own sorted copy of the table and the queue of responses still owed.
   class record_order_checker;
      logic [sirt_pkg::KEY_W-1:0]   keys [TABLE_DEPTH];
      logic [sirt_pkg::VALUE_W-1:0] values [TABLE_DEPTH];
      int                           fill;
      answer_type                   answers_due [$];
      int                           mismatches;
      int                           inserts_kept;
      int                           inserts_dropped;
      int                           dumps;
      int                           empty_dumps;
      int                           answers_checked;

      function new();
         fill            = 0;
         mismatches      = 0;
         inserts_kept    = 0;
         inserts_dropped = 0;
         dumps           = 0;
         empty_dumps     = 0;
         answers_checked = 0;
      endfunction

      function void take_request(logic op, logic [sirt_pkg::KEY_W-1:0] key,
                                 logic [sirt_pkg::VALUE_W-1:0] value);
         int         pos;
         int         i;
         answer_type want;
         want = '{status: sirt_pkg::STATUS_INSERTED, key: '0, value: '0, last: 1'b1};
         if (op == sirt_pkg::OP_INSERT) begin
            if (fill == TABLE_DEPTH) begin
               want.status = sirt_pkg::STATUS_FULL;
               inserts_dropped++;
            end else begin
               // new record goes ahead of any stored record with an equal key
               pos = 0;
               while (pos < fill && key > keys[pos])
                  pos++;
               for (i = fill; i > pos; i--) begin
                  keys[i]   = keys[i - 1];
                  values[i] = values[i - 1];
               end
               keys[pos]   = key;
               values[pos] = value;
               fill++;
               inserts_kept++;
            end
            answers_due.push_back(want);
         end else begin
            dumps++;
            if (fill == 0) begin
               want.status = sirt_pkg::STATUS_EMPTY;
               empty_dumps++;
               answers_due.push_back(want);
            end else begin
               for (i = 0; i < fill; i++) begin
                  want = '{status: sirt_pkg::STATUS_RECORD, key: keys[i], value: values[i],
                           last: (i == fill - 1)};
                  answers_due.push_back(want);
               end
            end
         end
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (answers_due.size() == 0) begin
            $error("unexpected response: status %0d key %h value %h last %0d",
                   got.status, got.key, got.value, got.last);
            mismatches++;
            return;
         end
         want = answers_due.pop_front();
         answers_checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.key !== want.key) begin
            $error("out_key: expected %h, got %h", want.key, got.key);
            mismatches++;
         end
         if (got.value !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, got.value);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic                         req_opcode    = sirt_pkg::OP_INSERT;
   logic [sirt_pkg::KEY_W-1:0]   req_rec_key   = '0;
   logic [sirt_pkg::VALUE_W-1:0] req_rec_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic [1:0]                   rsp_status;
   logic [sirt_pkg::KEY_W-1:0]   rsp_out_key;
   logic [sirt_pkg::VALUE_W-1:0] rsp_out_value;
   logic                         rsp_last;

   record_order_checker board = new();

   // request side alternates between gappy stretches and back-to-back runs
   bit req_steady   = 1'b0;
   int req_run_left = 0;

   sorted_insert_record_table_core #(.DEPTH(TABLE_DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   task automatic issue_request(input logic op, input logic [sirt_pkg::KEY_W-1:0] key,
                                input logic [sirt_pkg::VALUE_W-1:0] value);
      int gap;
      if (req_run_left == 0) begin
         req_steady   = ~req_steady;
         req_run_left = $urandom_range(5, 30);
      end
      req_run_left--;
      gap = req_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_rec_key   <= key;
      req_rec_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_request(op, key, value);
   endtask

   initial begin : stimulus
      int                           n;
      logic                         op;
      logic [sirt_pkg::KEY_W-1:0]   key;
      logic [sirt_pkg::VALUE_W-1:0] value;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      issue_request(sirt_pkg::OP_DUMP, '0, '0);             // dump of an empty table
      issue_request(sirt_pkg::OP_INSERT, 16'h8000, 8'h55);
      issue_request(sirt_pkg::OP_INSERT, 16'h0000, 8'hFF);
      issue_request(sirt_pkg::OP_INSERT, 16'hFFFF, 8'h00);
      issue_request(sirt_pkg::OP_INSERT, 16'h8000, 8'hAA);  // equal key, ahead of the older one
      issue_request(sirt_pkg::OP_DUMP, 16'hFFFF, 8'hFF);    // key and value ignored on a dump
      issue_request(sirt_pkg::OP_INSERT, 16'h0000, 8'h01);
      issue_request(sirt_pkg::OP_INSERT, 16'hFFFF, 8'h80);
      issue_request(sirt_pkg::OP_INSERT, 16'h7FFF, 8'h7F);
      issue_request(sirt_pkg::OP_DUMP, '0, '0);

      // table fills early; after that inserts are dropped and dumps return all sixteen
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         op    = ($urandom_range(0, 3) == 0) ? sirt_pkg::OP_DUMP : sirt_pkg::OP_INSERT;
         value = sirt_pkg::VALUE_W'($urandom);
         case ($urandom_range(0, 5))
            0:       key = '0;
            1:       key = '1;
            2:       key = sirt_pkg::KEY_W'($urandom_range(0, 7));
            default: key = sirt_pkg::KEY_W'($urandom);
         endcase
         issue_request(op, key, value);
      end
      @(negedge clock) req_valid <= 1'b0;

      while (board.answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d inserts stored, %0d refused on a full table, %0d dumps",
               board.inserts_kept + board.inserts_dropped + board.dumps, board.inserts_kept,
               board.inserts_dropped, board.dumps);
      $display("Checked %0d responses, %0d of them empty-table answers",
               board.answers_checked, board.empty_dumps);
      if (board.mismatches == 0 && board.answers_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : response_side
      int         hold;
      bit         steady;
      int         run_left;
      answer_type got;
      steady   = 1'b1;
      run_left = 0;
      wait (reset == 1'b0);
      forever begin
         if (run_left == 0) begin
            steady   = ~steady;
            run_left = $urandom_range(5, 40);
         end
         run_left--;
         hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
         @(negedge clock) rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = '{status: rsp_status, key: rsp_out_key, value: rsp_out_value, last: rsp_last};
         board.check_answer(got);
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
